// ===== rtl/fbc_pkg.sv =====
// shared types and constants for the frustum box cull block
package fbc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_COLS   = 4;
  localparam int NUM_AXES   = 3;
  localparam int COORD_W    = 24;
  localparam int ELEM_W     = 32;
  localparam int COEF_W     = ELEM_W + 1;
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int IDX_W      = 4;

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_BOX  = 1'b1;
  localparam logic [1:0] ROW_W     = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // one item as it travels down the chain of plane cells
  typedef struct packed {
    logic                          func;
    logic [IDX_W-1:0]              matrix_index;
    logic [ELEM_W-1:0]             matrix_value;
    logic [NUM_AXES-1:0][COORD_W-1:0] box_min;
    logic [NUM_AXES-1:0][COORD_W-1:0] box_max;
    logic                          vis;
  } token_t;

endpackage

// ===== rtl/fbc_cell.sv =====
// one plane cell: holds its plane coefficients, tests a box over two stages
module fbc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          plane_id,
  input  logic                up_valid,
  input  fbc_pkg::token_t     up_tok,
  output logic                up_ready,
  output logic                dn_valid,
  output fbc_pkg::token_t     dn_tok,
  input  logic                dn_ready
);

  fbc_pkg::elem_t e3_r   [fbc_pkg::NUM_COLS];
  fbc_pkg::elem_t e3_nxt [fbc_pkg::NUM_COLS];
  fbc_pkg::elem_t ek_r   [fbc_pkg::NUM_COLS];
  fbc_pkg::elem_t ek_nxt [fbc_pkg::NUM_COLS];
  fbc_pkg::coef_t coef_r   [fbc_pkg::NUM_COLS];
  fbc_pkg::coef_t coef_nxt [fbc_pkg::NUM_COLS];

  logic            a_valid_r;
  fbc_pkg::token_t a_tok_r;
  fbc_pkg::prod_t  a_prod_r   [fbc_pkg::NUM_AXES];
  fbc_pkg::prod_t  a_prod_nxt [fbc_pkg::NUM_AXES];
  fbc_pkg::coef_t  a_off_r;

  logic            b_valid_r;
  fbc_pkg::token_t b_tok_r;
  fbc_pkg::token_t b_tok_nxt;

  logic            b_ready;
  logic            up_take;
  logic [1:0]      plane_k;
  logic            plane_neg;
  logic [1:0]      ld_col;
  logic [1:0]      ld_row;
  fbc_pkg::elem_t  ld_val;
  fbc_pkg::acc_t   acc;

  assign plane_k   = plane_id[2:1];
  assign plane_neg = plane_id[0];
  assign ld_col    = up_tok.matrix_index[3:2];
  assign ld_row    = up_tok.matrix_index[1:0];
  assign ld_val    = $signed(up_tok.matrix_value);

  assign b_ready  = !b_valid_r || dn_ready;
  assign up_ready = !a_valid_r || b_ready;
  assign up_take  = up_valid && up_ready;

  // loads update the coefficients in item order, so a box behind a load sees it
  always_comb begin
    for (int c = 0; c < fbc_pkg::NUM_COLS; c++) begin
      e3_nxt[c]   = e3_r[c];
      ek_nxt[c]   = ek_r[c];
      coef_nxt[c] = coef_r[c];
    end
    if (up_take && up_tok.func == fbc_pkg::FUNC_LOAD) begin
      if (ld_row == fbc_pkg::ROW_W) begin
        e3_nxt[ld_col]   = ld_val;
        coef_nxt[ld_col] = plane_neg
            ? fbc_pkg::coef_t'(ld_val) - fbc_pkg::coef_t'(ek_r[ld_col])
            : fbc_pkg::coef_t'(ld_val) + fbc_pkg::coef_t'(ek_r[ld_col]);
      end else if (ld_row == plane_k) begin
        ek_nxt[ld_col]   = ld_val;
        coef_nxt[ld_col] = plane_neg
            ? fbc_pkg::coef_t'(e3_r[ld_col]) - fbc_pkg::coef_t'(ld_val)
            : fbc_pkg::coef_t'(e3_r[ld_col]) + fbc_pkg::coef_t'(ld_val);
      end
    end
  end

  // positive vertex: max corner where the coefficient is non-negative
  always_comb begin
    for (int c = 0; c < fbc_pkg::NUM_AXES; c++) begin
      if (coef_r[c][fbc_pkg::COEF_W-1]) begin
        a_prod_nxt[c] = fbc_pkg::prod_t'(coef_r[c]) *
                        fbc_pkg::prod_t'($signed(up_tok.box_min[c]));
      end else begin
        a_prod_nxt[c] = fbc_pkg::prod_t'(coef_r[c]) *
                        fbc_pkg::prod_t'($signed(up_tok.box_max[c]));
      end
    end
  end

  assign acc = fbc_pkg::acc_t'(a_prod_r[0]) + fbc_pkg::acc_t'(a_prod_r[1]) +
               fbc_pkg::acc_t'(a_prod_r[2]) + fbc_pkg::acc_t'(a_off_r);

  always_comb begin
    b_tok_nxt     = a_tok_r;
    b_tok_nxt.vis = a_tok_r.vis && !acc[fbc_pkg::ACC_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      for (int c = 0; c < fbc_pkg::NUM_COLS; c++) begin
        e3_r[c]   <= '0;
        ek_r[c]   <= '0;
        coef_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < fbc_pkg::NUM_COLS; c++) begin
        e3_r[c]   <= e3_nxt[c];
        ek_r[c]   <= ek_nxt[c];
        coef_r[c] <= coef_nxt[c];
      end
      if (up_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) begin
      a_tok_r <= up_tok;
      a_off_r <= coef_r[3];
      for (int c = 0; c < fbc_pkg::NUM_AXES; c++) begin
        a_prod_r[c] <= a_prod_nxt[c];
      end
    end
    if (b_ready && a_valid_r) begin
      b_tok_r <= b_tok_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_tok   = b_tok_r;

endmodule

// ===== rtl/frustum_box_cull_top.sv =====
// top level of the frustum box cull block: a chain of six plane cells
// Every item, load or box, walks a chain of six plane cells, one per clip plane,
// each two register stages deep (products, then sum and sign test), and a new
// item can be taken every cycle unless a result-side stall has backed the chain
// up to the input. Load items write a matrix element and give no result; they
// travel the same chain and update each cell's plane coefficients as they pass,
// so every box is tested against exactly the matrix loaded before it. Stalls on
// the result side back up stage by stage; empty stages keep taking items.
module frustum_box_cull_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [3:0]  in_matrix_index,
  input  logic signed [31:0] in_matrix_value,
  input  logic signed [23:0] in_box_min_x,
  input  logic signed [23:0] in_box_min_y,
  input  logic signed [23:0] in_box_min_z,
  input  logic signed [23:0] in_box_max_x,
  input  logic signed [23:0] in_box_max_y,
  input  logic signed [23:0] in_box_max_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_visible
);

  logic            link_valid [fbc_pkg::NUM_PLANES+1];
  logic            link_ready [fbc_pkg::NUM_PLANES+1];
  fbc_pkg::token_t link_tok   [fbc_pkg::NUM_PLANES+1];

  always_comb begin
    link_tok[0].func         = in_func;
    link_tok[0].matrix_index = in_matrix_index;
    link_tok[0].matrix_value = in_matrix_value;
    link_tok[0].box_min[0]   = in_box_min_x;
    link_tok[0].box_min[1]   = in_box_min_y;
    link_tok[0].box_min[2]   = in_box_min_z;
    link_tok[0].box_max[0]   = in_box_max_x;
    link_tok[0].box_max[1]   = in_box_max_y;
    link_tok[0].box_max[2]   = in_box_max_z;
    link_tok[0].vis          = 1'b1;
  end

  assign link_valid[0] = in_valid;
  assign in_ready      = link_ready[0];

  for (genvar i = 0; i < fbc_pkg::NUM_PLANES; i++) begin : g_cell
    fbc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane_id (3'(i)),
      .up_valid (link_valid[i]),
      .up_tok   (link_tok[i]),
      .up_ready (link_ready[i]),
      .dn_valid (link_valid[i+1]),
      .dn_tok   (link_tok[i+1]),
      .dn_ready (link_ready[i+1])
    );
  end

  // load items leave the chain here without a result
  assign out_valid = link_valid[fbc_pkg::NUM_PLANES] &&
                     link_tok[fbc_pkg::NUM_PLANES].func == fbc_pkg::FUNC_BOX;
  assign link_ready[fbc_pkg::NUM_PLANES] =
      out_ready || link_tok[fbc_pkg::NUM_PLANES].func == fbc_pkg::FUNC_LOAD;
  assign out_visible = link_tok[fbc_pkg::NUM_PLANES].vis;

endmodule

// ===== rtl/fbc_checker.sv =====
// port-level checks for the frustum box cull block, bound to the top level
module fbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_visible
);

  localparam int MAX_PENDING = 2 * fbc_pkg::NUM_PLANES;

  logic [4:0] pending_r;
  logic [4:0] pending_nxt;
  logic       box_in;
  logic       res_out;

  assign box_in  = in_valid && in_ready && in_func == fbc_pkg::FUNC_BOX;
  assign res_out = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (box_in && !res_out) begin
      pending_nxt = pending_r + 5'd1;
    end else if (!box_in && res_out) begin
      pending_nxt = pending_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_visible))
    else $error("stalled result changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> pending_r != 5'd0)
    else $error("result without a box item in flight");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
      pending_r <= 5'(MAX_PENDING))
    else $error("more box items in flight than the chain holds");

endmodule

bind frustum_box_cull_top fbc_checker u_fbc_checker (.*);

// ===== bench/tb.sv =====
// testbench for the frustum box cull block: random matrix loads and box tests
`timescale 1ns / 100ps

module tb;

  localparam int     NUM_ITEMS   = 2000;
  localparam int     CYCLE_LIMIT = 500000;
  localparam int     DRAIN_WAIT  = 40;
  localparam fbc_pkg::coord_t C_LO  = {1'b1, {(fbc_pkg::COORD_W-1){1'b0}}};
  localparam fbc_pkg::coord_t C_HI  = {1'b0, {(fbc_pkg::COORD_W-1){1'b1}}};
  localparam fbc_pkg::elem_t  E_LO  = 32'h8000_0000;
  localparam fbc_pkg::elem_t  E_HI  = 32'h7fff_ffff;
  localparam fbc_pkg::elem_t  E_ONE = 32'h0001_0000;

  typedef struct packed {
    logic                      func;
    logic [fbc_pkg::IDX_W-1:0] idx;
    fbc_pkg::elem_t            val;
    fbc_pkg::coord_t           min_x, min_y, min_z;
    fbc_pkg::coord_t           max_x, max_y, max_z;
  } cull_item_t;

  class cull_scoreboard;
    fbc_pkg::elem_t view_mat[16];
    bit    visible_q[$];
    int    errors;

    function new();
      foreach (view_mat[i]) view_mat[i] = '0;
      errors = 0;
    endfunction

    // sign test of the six extracted planes against the positive vertex
    function bit box_visible(cull_item_t it);
      fbc_pkg::coord_t lo[3];
      fbc_pkg::coord_t hi[3];
      fbc_pkg::coef_t  cf[4];
      fbc_pkg::acc_t   acc;
      int     k;
      bit     vis;
      lo[0] = it.min_x; lo[1] = it.min_y; lo[2] = it.min_z;
      hi[0] = it.max_x; hi[1] = it.max_y; hi[2] = it.max_z;
      vis = 1'b1;
      for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
        k = p / 2;
        for (int c = 0; c < fbc_pkg::NUM_COLS; c++) begin
          if (p % 2 != 0) begin
            cf[c] = fbc_pkg::coef_t'(view_mat[c*4 + fbc_pkg::ROW_W]) -
                    fbc_pkg::coef_t'(view_mat[c*4 + k]);
          end else begin
            cf[c] = fbc_pkg::coef_t'(view_mat[c*4 + fbc_pkg::ROW_W]) +
                    fbc_pkg::coef_t'(view_mat[c*4 + k]);
          end
        end
        acc = fbc_pkg::acc_t'(cf[3]);
        for (int c = 0; c < fbc_pkg::NUM_AXES; c++) begin
          acc = acc + fbc_pkg::acc_t'(cf[c]) *
                      fbc_pkg::acc_t'((cf[c] >= 0) ? hi[c] : lo[c]);
        end
        if (acc < 0) vis = 1'b0;
      end
      return vis;
    endfunction

    function void note_item(cull_item_t it);
      if (it.func == fbc_pkg::FUNC_LOAD) begin
        view_mat[it.idx] = it.val;
      end else begin
        visible_q = {visible_q, box_visible(it)};
      end
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic vis);
      bit want;
      if (visible_q.size() == 0) begin
        report($sformatf("visible=%b with no box outstanding", vis));
      end else begin
        want = visible_q.pop_front();
        if (vis !== want) report($sformatf("visible=%b, wanted %b", vis, want));
      end
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic         in_func;
  logic [3:0]   in_matrix_index;
  fbc_pkg::elem_t  in_matrix_value;
  fbc_pkg::coord_t in_box_min_x, in_box_min_y, in_box_min_z;
  fbc_pkg::coord_t in_box_max_x, in_box_max_y, in_box_max_z;
  logic         out_valid;
  logic         out_ready;
  logic         out_visible;

  cull_scoreboard sb = new();
  bit    steady;
  int    items_sent;
  int    cycles;
  fbc_pkg::elem_t scene_mat[16];

  always #10 clk = ~clk;

  frustum_box_cull_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_matrix_index (in_matrix_index),
    .in_matrix_value (in_matrix_value),
    .in_box_min_x    (in_box_min_x),
    .in_box_min_y    (in_box_min_y),
    .in_box_min_z    (in_box_min_z),
    .in_box_max_x    (in_box_max_x),
    .in_box_max_y    (in_box_max_y),
    .in_box_max_z    (in_box_max_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_visible     (out_visible)
  );

  function automatic logic [3:0] elem_pos(int col, int row);
    return 4'(col*4 + row);
  endfunction

  function automatic cull_item_t make_load(logic [3:0] idx, fbc_pkg::elem_t val);
    cull_item_t it;
    it.func  = fbc_pkg::FUNC_LOAD;
    it.idx   = idx;
    it.val   = val;
    it.min_x = fbc_pkg::coord_t'($urandom); it.min_y = fbc_pkg::coord_t'($urandom);
    it.min_z = fbc_pkg::coord_t'($urandom); it.max_x = fbc_pkg::coord_t'($urandom);
    it.max_y = fbc_pkg::coord_t'($urandom); it.max_z = fbc_pkg::coord_t'($urandom);
    return it;
  endfunction

  function automatic cull_item_t make_box(
      fbc_pkg::coord_t lx, fbc_pkg::coord_t ly, fbc_pkg::coord_t lz,
      fbc_pkg::coord_t hx, fbc_pkg::coord_t hy, fbc_pkg::coord_t hz);
    cull_item_t it;
    it.func  = fbc_pkg::FUNC_BOX;
    it.idx   = 4'($urandom);
    it.val   = fbc_pkg::elem_t'($urandom);
    it.min_x = lx; it.min_y = ly; it.min_z = lz;
    it.max_x = hx; it.max_y = hy; it.max_z = hz;
    return it;
  endfunction

  // box around a random center within +-span, sometimes turned inside out
  function automatic cull_item_t scene_box(int span);
    int     ctr, half;
    fbc_pkg::coord_t lo[3];
    fbc_pkg::coord_t hi[3];
    fbc_pkg::coord_t t;
    for (int a = 0; a < fbc_pkg::NUM_AXES; a++) begin
      ctr   = int'($urandom_range(0, 2*span)) - span;
      half  = int'($urandom_range(0, span/2));
      lo[a] = fbc_pkg::coord_t'(ctr - half);
      hi[a] = fbc_pkg::coord_t'(ctr + half);
      if ($urandom_range(0, 9) == 0) begin
        t = lo[a]; lo[a] = hi[a]; hi[a] = t;
      end
    end
    return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic send_item(input cull_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= it.func;
    in_matrix_index <= it.idx;
    in_matrix_value <= it.val;
    in_box_min_x    <= it.min_x;
    in_box_min_y    <= it.min_y;
    in_box_min_z    <= it.min_z;
    in_box_max_x    <= it.max_x;
    in_box_max_y    <= it.max_y;
    in_box_max_z    <= it.max_z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  // whole matrix in a scrambled element order
  task automatic load_scene_matrix();
    int start, step;
    logic [3:0] pos;
    start = $urandom_range(0, 15);
    step  = 2*$urandom_range(0, 7) + 1;
    for (int i = 0; i < 16; i++) begin
      pos = 4'(start + i*step);
      send_item(make_load(pos, scene_mat[pos]));
    end
  endtask

  // result side back-pressure
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_visible);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int kind, span, boxes, pick, r;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_func         <= fbc_pkg::FUNC_LOAD;
    in_matrix_index <= '0;
    in_matrix_value <= '0;
    in_box_min_x    <= '0;
    in_box_min_y    <= '0;
    in_box_min_z    <= '0;
    in_box_max_x    <= '0;
    in_box_max_y    <= '0;
    in_box_max_z    <= '0;
    steady     = 1'b0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // zero matrix from reset: every plane is zero, so the box passes
    send_item(make_box(C_LO, C_LO, C_LO, C_HI, C_HI, C_HI));
    // zero normals, only the offset sign decides
    send_item(make_load(elem_pos(3, 3), E_LO));
    send_item(make_box(-24'sd5, -24'sd5, -24'sd5, 24'sd5, 24'sd5, 24'sd5));
    send_item(make_load(elem_pos(3, 3), E_HI));
    send_item(make_box(-24'sd5, -24'sd5, -24'sd5, 24'sd5, 24'sd5, 24'sd5));
    // extreme coefficients against extreme corners
    send_item(make_load(elem_pos(0, 0), E_HI));
    send_item(make_load(elem_pos(0, 3), E_HI));
    send_item(make_load(elem_pos(1, 1), E_LO));
    send_item(make_load(elem_pos(1, 3), E_LO));
    send_item(make_load(elem_pos(2, 2), E_ONE));
    send_item(make_box(C_LO, C_LO, C_LO, C_HI, C_HI, C_HI));
    // inside-out box keeps its corners as given
    send_item(make_box(C_HI, C_HI, C_HI, C_LO, C_LO, C_LO));
    send_item(make_box(C_LO, C_LO, C_LO, C_LO, C_LO, C_LO));
    send_item(make_box(C_HI, C_HI, C_HI, C_HI, C_HI, C_HI));
    send_item(make_load(elem_pos(3, 2), 32'hffff_0000));
    send_item(make_box('0, '0, '0, '0, '0, '0));

    while (items_sent < NUM_ITEMS) begin
      pick   = $urandom_range(0, 3);
      kind   = (pick < 2) ? 0 : pick - 1;
      steady = ($urandom_range(0, 4) == 0);
      foreach (scene_mat[i]) scene_mat[i] = '0;
      case (kind)
        0: begin
          // axis-aligned view volume of half size r divided by each axis scale, around a shifted origin
          r = $urandom_range(1, 1000);
          for (int a = 0; a < fbc_pkg::NUM_AXES; a++) begin
            scene_mat[elem_pos(a, a)] =
              fbc_pkg::elem_t'($urandom_range(1, 4) * 65536);
            scene_mat[elem_pos(3, a)] =
              fbc_pkg::elem_t'((int'($urandom_range(0, r)) - r/2) * 65536);
          end
          scene_mat[elem_pos(3, 3)] = fbc_pkg::elem_t'(r * 65536);
          span = 2*r;
        end
        1: begin
          foreach (scene_mat[i])
            scene_mat[i] =
              fbc_pkg::elem_t'(int'($urandom_range(0, 8*65536)) - 4*65536);
          span = $urandom_range(1, 2000);
        end
        default: begin
          foreach (scene_mat[i]) scene_mat[i] = fbc_pkg::elem_t'($urandom);
          span = $urandom_range(1, 4000000);
        end
      endcase
      load_scene_matrix();
      boxes = $urandom_range(10, 60);
      for (int j = 0; j < boxes; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_item(make_load(4'($urandom), fbc_pkg::elem_t'($urandom)));
        end else if (pick < 10) begin
          send_item(make_box(fbc_pkg::coord_t'($urandom), fbc_pkg::coord_t'($urandom),
                             fbc_pkg::coord_t'($urandom), fbc_pkg::coord_t'($urandom),
                             fbc_pkg::coord_t'($urandom), fbc_pkg::coord_t'($urandom)));
        end else begin
          send_item(scene_box(span));
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.visible_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.visible_q.size() != 0)
      sb.report($sformatf("%0d boxes never answered", sb.visible_q.size()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
